// ----- hw/rtl/hcte_pkg.sv -----
// hcte_pkg: shared types, command codes and sizes of the host command transfer engine
// no dependencies; used by every module of the block except hcte_ram
`default_nettype none

package hcte_pkg;

	localparam int SCRATCH_DEPTH = 256;
	localparam int SCR_AW = $clog2(SCRATCH_DEPTH);
	localparam int STORE_IDX_W = 8;
	localparam logic [STORE_IDX_W:0] DEPTH_LIM = (STORE_IDX_W + 1)'(SCRATCH_DEPTH);
	localparam int CFG_IDX_W = 8;

	// idle commands
	localparam logic [7:0] CMD_VERSION  = 8'h00;
	localparam logic [7:0] CMD_DIGITAL  = 8'h01;
	localparam logic [7:0] CMD_ANALOG_A = 8'h02;
	localparam logic [7:0] CMD_ANALOG_B = 8'h03;
	localparam logic [7:0] CMD_COMMIT   = 8'h04;
	localparam logic [7:0] CMD_PLAYER   = 8'h10;
	localparam logic [7:0] CMD_SAVE     = 8'h11;
	localparam logic [7:0] CMD_LOAD     = 8'h12;
	localparam logic [7:0] CMD_MODE     = 8'h13;
	localparam logic [7:0] CMD_SPACE    = 8'hf0;
	localparam logic [7:0] CMD_ADDR_LO  = 8'hf1;
	localparam logic [7:0] CMD_ADDR_HI  = 8'hf2;
	localparam logic [7:0] CMD_LENGTH   = 8'hf3;
	localparam logic [7:0] CMD_WRITE    = 8'hf4;
	localparam logic [7:0] CMD_READ     = 8'hf5;

	// transaction codes and reply bytes
	localparam logic [7:0] TX_NONE      = 8'h00;
	localparam logic [7:0] TX_DATA      = 8'h0b;
	localparam logic [7:0] CONFIRM_WR   = 8'h0b;
	localparam logic [7:0] CONFIRM_RD   = 8'h0a;
	localparam logic [7:0] BYTE_ERR     = 8'he0;
	localparam logic [7:0] BYTE_FILL    = 8'hff;

	// settings request codes
	localparam logic [1:0] REQ_NONE   = 2'd0;
	localparam logic [1:0] REQ_COMMIT = 2'd1;
	localparam logic [1:0] REQ_SAVE   = 2'd2;
	localparam logic [1:0] REQ_LOAD   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VER_MAJOR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VER_MINOR = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_VER_PATCH = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MAP_SIZE  = CFG_IDX_W'(3);

	typedef struct packed {
		logic [7:0]  command_byte;
		logic [15:0] raw_digital;
		logic [7:0]  analog_one;
		logic [7:0]  analog_two;
		logic [7:0]  analog_three;
		logic [7:0]  analog_four;
		logic [7:0]  analog_five;
		logic [7:0]  analog_six;
	} in_t;

	typedef struct packed {
		logic [7:0] reply_zero;
		logic [7:0] reply_one;
		logic [7:0] reply_two;
		logic [7:0] reply_three;
		logic       player_select;
		logic [1:0] settings_request;
		logic       mode_write;
		logic [7:0] mode_value;
	} out_t;

	typedef struct packed {
		logic [7:0] ver_major;
		logic [7:0] ver_minor;
		logic [7:0] ver_patch;
		logic [7:0] map_size;
	} cfg_t;

	// access to the scratch store
	typedef struct packed {
		logic                   rd;
		logic                   wr;
		logic                   miss;
		logic [STORE_IDX_W-1:0] index;
		logic [7:0]             wdata;
	} mem_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hcte_ram.sv -----
// hcte_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module hcte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hcte_store.sv -----
// hcte_store: scratch store with per-entry valid bits, range check and zero fill
// depends on hcte_pkg and hcte_ram
`default_nettype none

module hcte_store (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hcte_pkg::mem_req_t req,
	output logic [7:0]              rdata
);

	logic                                 in_rng;
	logic                                 hit;
	logic [hcte_pkg::SCR_AW-1:0]          addr;
	logic [hcte_pkg::SCRATCH_DEPTH-1:0]   vld_q;
	logic                                 ok_s1;
	logic [7:0]                           ram_rd;

	assign in_rng = {1'b0, req.index} < hcte_pkg::DEPTH_LIM;
	assign hit = in_rng && !req.miss;
	assign addr = req.index[hcte_pkg::SCR_AW-1:0];

	hcte_ram #(
		.WIDTH(8),
		.DEPTH(hcte_pkg::SCRATCH_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (req.wr && hit),
		.addr (addr),
		.wdata(req.wdata),
		.rdata(ram_rd)
	);

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ok_s1 <= 1'b0;
		end else begin
			if (req.wr && hit) begin
				vld_q[addr] <= 1'b1;
			end
			ok_s1 <= req.rd && hit && vld_q[addr];
		end
	end

	assign rdata = ok_s1 ? ram_rd : 8'h00;

endmodule

`default_nettype wire

// ----- hw/rtl/hcte_ctrl.sv -----
// hcte_ctrl: command decoder and transaction sequencer around the scratch store
// depends on hcte_pkg and hcte_store
`default_nettype none

module hcte_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire hcte_pkg::in_t  in_data,
	input  wire hcte_pkg::cfg_t cfg,
	input  wire logic           res_free,
	output logic                busy,
	output logic                res_push,
	output hcte_pkg::out_t      res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MEM0,
		S_STREAM,
		S_PUSH
	} state_t;

	state_t             state_q;
	logic [7:0]         otx_q;
	logic [7:0]         space_q;
	logic [15:0]        addr_q;
	logic [7:0]         len_q;
	logic [7:0]         chk_q;
	logic               player_q;
	logic [1:0]         cnt_q;
	logic [7:0]         rdptr_q;
	logic [7:0]         cmd_q;
	hcte_pkg::out_t     res_q;
	hcte_pkg::mem_req_t mreq;
	logic [7:0]         mdata;
	logic [7:0]         c;
	logic [7:0]         sbyte;
	logic [7:0]         len_dec;
	logic [7:0]         r0;
	logic [7:0]         r1;
	logic [7:0]         r2;
	logic               idle_ok;
	logic [1:0]         req_c;

	assign c = in_data.command_byte;
	assign len_dec = len_q - 8'd1;

	hcte_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rdata (mdata)
	);

	// store requests: write data, scratch byte 0 and stream reads
	always_comb begin
		mreq = '0;
		mreq.wdata = c;
		if (accept && state_q == S_IDLE) begin
			if (otx_q == hcte_pkg::TX_NONE) begin
				if (c == hcte_pkg::CMD_PLAYER || c == hcte_pkg::CMD_MODE) begin
					mreq.rd = 1'b1;
				end
			end else if (otx_q == hcte_pkg::TX_DATA) begin
				mreq.wr = 1'b1;
				mreq.miss = space_q != 8'h00;
				mreq.index = addr_q[7:0];
			end else if (otx_q == hcte_pkg::CMD_READ && c == hcte_pkg::CONFIRM_RD) begin
				mreq.rd = 1'b1;
				mreq.miss = space_q != 8'h00;
				mreq.index = addr_q[7:0];
			end
		end else if (state_q == S_STREAM && cnt_q != 2'd3) begin
			mreq.rd = 1'b1;
			mreq.miss = space_q != 8'h00;
			mreq.index = rdptr_q;
		end
	end

	// idle command decode
	always_comb begin
		r0 = 8'h00;
		r1 = 8'h00;
		r2 = 8'h00;
		idle_ok = 1'b1;
		req_c = hcte_pkg::REQ_NONE;
		case (c)
			hcte_pkg::CMD_VERSION: begin
				r0 = cfg.ver_major;
				r1 = cfg.ver_minor;
				r2 = cfg.ver_patch;
			end
			hcte_pkg::CMD_DIGITAL: begin
				r0 = in_data.raw_digital[15:8];
				r1 = in_data.raw_digital[7:0];
			end
			hcte_pkg::CMD_ANALOG_A: begin
				r0 = in_data.analog_one;
				r1 = in_data.analog_two;
				r2 = in_data.analog_three;
			end
			hcte_pkg::CMD_ANALOG_B: begin
				r0 = in_data.analog_four;
				r1 = in_data.analog_five;
				r2 = in_data.analog_six;
			end
			hcte_pkg::CMD_COMMIT: begin
				req_c = hcte_pkg::REQ_COMMIT;
				r0 = cfg.map_size;
			end
			hcte_pkg::CMD_SAVE: begin
				req_c = hcte_pkg::REQ_SAVE;
				r0 = cfg.map_size;
			end
			hcte_pkg::CMD_LOAD: begin
				req_c = hcte_pkg::REQ_LOAD;
				r0 = cfg.map_size;
			end
			hcte_pkg::CMD_PLAYER, hcte_pkg::CMD_MODE: begin
				// finished once scratch byte 0 is back
			end
			hcte_pkg::CMD_SPACE, hcte_pkg::CMD_ADDR_LO, hcte_pkg::CMD_ADDR_HI,
			hcte_pkg::CMD_LENGTH, hcte_pkg::CMD_WRITE, hcte_pkg::CMD_READ: begin
				r0 = c;
				r1 = c;
				r2 = c;
			end
			default: begin
				idle_ok = 1'b0;
				r0 = c;
				r1 = hcte_pkg::BYTE_FILL;
				r2 = hcte_pkg::BYTE_FILL;
			end
		endcase
	end

	// stream byte: once the length is spent the check byte repeats
	assign sbyte = (len_q == 8'h00) ? chk_q : mdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			otx_q <= hcte_pkg::TX_NONE;
			space_q <= 8'h00;
			addr_q <= 16'h0000;
			len_q <= 8'h00;
			chk_q <= 8'h00;
			player_q <= 1'b0;
			cnt_q <= 2'd0;
			rdptr_q <= 8'h00;
			cmd_q <= 8'h00;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= c;
						res_q <= '0;
						res_q.player_select <= player_q;
						res_q.reply_zero <= c;
						res_q.reply_one <= c;
						res_q.reply_two <= c;
						res_q.reply_three <= c;
						state_q <= S_PUSH;
						if (otx_q == hcte_pkg::TX_NONE) begin
							res_q.reply_zero <= r0;
							res_q.reply_one <= r1;
							res_q.reply_two <= r2;
							res_q.reply_three <= idle_ok ? (c ^ r0 ^ r1 ^ r2)
								: hcte_pkg::BYTE_ERR;
							res_q.settings_request <= req_c;
							if (c == hcte_pkg::CMD_PLAYER || c == hcte_pkg::CMD_MODE) begin
								state_q <= S_MEM0;
							end
							if (c == hcte_pkg::CMD_SPACE || c == hcte_pkg::CMD_ADDR_LO ||
								c == hcte_pkg::CMD_ADDR_HI || c == hcte_pkg::CMD_LENGTH ||
								c == hcte_pkg::CMD_WRITE || c == hcte_pkg::CMD_READ) begin
								otx_q <= c;
								chk_q <= 8'h00;
							end
						end else begin
							case (otx_q)
								hcte_pkg::CMD_SPACE: begin
									space_q <= c;
									otx_q <= hcte_pkg::TX_NONE;
								end
								hcte_pkg::CMD_ADDR_LO: begin
									addr_q[7:0] <= c;
									otx_q <= hcte_pkg::TX_NONE;
								end
								hcte_pkg::CMD_ADDR_HI: begin
									addr_q[15:8] <= c;
									otx_q <= hcte_pkg::TX_NONE;
								end
								hcte_pkg::CMD_LENGTH: begin
									len_q <= c;
									otx_q <= hcte_pkg::TX_NONE;
								end
								hcte_pkg::CMD_WRITE: begin
									if (c == hcte_pkg::CONFIRM_WR) begin
										otx_q <= hcte_pkg::TX_DATA;
									end else begin
										otx_q <= hcte_pkg::TX_NONE;
										res_q.reply_three <= hcte_pkg::BYTE_ERR;
									end
								end
								hcte_pkg::TX_DATA: begin
									addr_q <= addr_q + 16'd1;
									len_q <= len_dec;
									if (len_dec == 8'h00) begin
										otx_q <= hcte_pkg::TX_NONE;
									end
								end
								hcte_pkg::CMD_READ: begin
									if (c == hcte_pkg::CONFIRM_RD) begin
										rdptr_q <= addr_q[7:0] + 8'd1;
										cnt_q <= 2'd0;
										state_q <= S_STREAM;
									end else begin
										otx_q <= hcte_pkg::TX_NONE;
										res_q.reply_three <= hcte_pkg::BYTE_ERR;
									end
								end
								default: begin
									otx_q <= hcte_pkg::TX_NONE;
									res_q.reply_three <= hcte_pkg::BYTE_ERR;
								end
							endcase
						end
					end
				end
				S_MEM0: begin
					if (cmd_q == hcte_pkg::CMD_PLAYER) begin
						player_q <= mdata[0];
						res_q.player_select <= mdata[0];
						res_q.reply_zero <= {7'b0, mdata[0]};
						res_q.reply_three <= cmd_q ^ {7'b0, mdata[0]};
					end else begin
						res_q.mode_write <= 1'b1;
						res_q.mode_value <= mdata;
						res_q.reply_zero <= mdata;
						res_q.reply_three <= cmd_q ^ mdata;
					end
					state_q <= S_PUSH;
				end
				S_STREAM: begin
					if (len_q == 8'h00) begin
						otx_q <= hcte_pkg::TX_NONE;
					end else begin
						addr_q <= addr_q + 16'd1;
						chk_q <= chk_q ^ mdata;
						len_q <= len_dec;
					end
					case (cnt_q)
						2'd0: res_q.reply_zero <= sbyte;
						2'd1: res_q.reply_one <= sbyte;
						2'd2: res_q.reply_two <= sbyte;
						default: res_q.reply_three <= sbyte;
					endcase
					rdptr_q <= rdptr_q + 8'd1;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign res_push = state_q == S_PUSH && res_free;
	assign res = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/host_command_transfer_engine.sv -----
// host_command_transfer_engine: top level with configuration registers and output register
// depends on hcte_pkg and hcte_ctrl
//
// Usage: one host byte per request enters on in_valid/in_stall as in_data; each request
// gives exactly one reply on out_valid/out_stall as out_data (four reply bytes plus the
// player select, settings request and mode strobes).
// Configuration registers (version bytes, map size) are written on cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high and unknown indexes are dropped.
// Timing: a request is taken only while the sequencer is idle. Plain commands and
// transaction parameters go from acceptance straight to the push state; player select
// and mode store read scratch byte 0 in a memory state first; a confirmed stream reads
// its four store bytes in the stream state, one per cycle through the single read/write
// port of the scratch ram. The next request is taken in the cycle after the reply is loaded.
// The reply sits in an output register: while the receiver stalls, the sequencer can take
// one more request and holds its finished reply until the register frees.
// Reset clears the sequencer, transaction state, registers and all scratch valid bits, so
// the whole store reads as zero straight after reset with no clearing pass.
`default_nettype none

module host_command_transfer_engine (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire hcte_pkg::in_t                    in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output hcte_pkg::out_t                        out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [hcte_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [7:0]                       cfg_data
);

	hcte_pkg::cfg_t cfg_q;
	hcte_pkg::out_t out_q;
	hcte_pkg::out_t res;
	logic           out_valid_q;
	logic           busy;
	logic           res_push;
	logic           res_free;
	logic           accept;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hcte_pkg::REG_VER_MAJOR: cfg_q.ver_major <= cfg_data;
				hcte_pkg::REG_VER_MINOR: cfg_q.ver_minor <= cfg_data;
				hcte_pkg::REG_VER_PATCH: cfg_q.ver_patch <= cfg_data;
				hcte_pkg::REG_MAP_SIZE: cfg_q.map_size <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hcte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_data (in_data),
		.cfg     (cfg_q),
		.res_free(res_free),
		.busy    (busy),
		.res_push(res_push),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign in_stall = busy;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// every accepted request makes the sequencer busy in the cycle after it
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted without sequencer going busy");

	// a new reply is only loaded from the sequencer's busy phase
	a_reply_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("reply appeared without a request in flight");

	// mode value is only carried with the mode strobe
	a_mode_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.mode_write) |-> out_data.mode_value == 8'h00)
		else $error("mode value set without mode strobe");

	// strobes never fire together
	a_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.mode_write) |-> out_data.settings_request == hcte_pkg::REQ_NONE)
		else $error("mode strobe together with settings request");

endmodule

`default_nettype wire

// ----- bench/host_command_transfer_engine_tb.sv -----
// host_command_transfer_engine_tb: self-checking bench for the host command transfer engine
// drives host bytes, register writes and reply stalls; predicts every reply in a scoreboard class
// depends on hcte_pkg and host_command_transfer_engine
`timescale 1ns / 1ps

module host_command_transfer_engine_tb;
	import hcte_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 4;
	localparam int REQUESTS_PER_PHASE = 350;

	class host_engine_mirror;
		logic [7:0]  scratch_mem [0:255];
		logic [7:0]  open_code;
		logic [7:0]  space_sel;
		logic [15:0] xfer_addr;
		logic [7:0]  xfer_len;
		logic [7:0]  stream_check;
		logic        player_sel;
		cfg_t        regs;
		out_t        awaited_replies[$];
		int          requests_taken;
		int          replies_matched;
		int          store_writes;
		int          streamed_bytes;
		int          error_replies;
		int          mismatches;

		function new();
			foreach (scratch_mem[i]) scratch_mem[i] = '0;
			open_code = TX_NONE;
			space_sel = '0;
			xfer_addr = '0;
			xfer_len = '0;
			stream_check = '0;
			player_sel = 1'b0;
			regs = '0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				REG_VER_MAJOR: regs.ver_major = val;
				REG_VER_MINOR: regs.ver_minor = val;
				REG_VER_PATCH: regs.ver_patch = val;
				REG_MAP_SIZE:  regs.map_size = val;
				default: ;
			endcase
		endfunction

		// only space zero maps onto the store
		function bit store_index(output int idx);
			idx = int'(xfer_addr[7:0]);
			return space_sel == '0 && idx < SCRATCH_DEPTH;
		endfunction

		function logic [7:0] stream_byte();
			int idx;
			logic [7:0] v;
			if (xfer_len == '0) begin
				open_code = TX_NONE;
				return stream_check;
			end
			v = store_index(idx) ? scratch_mem[idx] : 8'h00;
			xfer_addr++;
			stream_check ^= v;
			xfer_len--;
			streamed_bytes++;
			return v;
		endfunction

		function out_t next_reply(in_t d);
			out_t r;
			logic [7:0] c;
			bit ok;
			bit streamed;
			int idx;
			r = '0;
			c = d.command_byte;
			ok = 1'b1;
			streamed = 1'b0;
			if (open_code != TX_NONE) begin
				case (open_code)
					CMD_SPACE: begin
						space_sel = c;
						open_code = TX_NONE;
					end
					CMD_ADDR_LO: begin
						xfer_addr[7:0] = c;
						open_code = TX_NONE;
					end
					CMD_ADDR_HI: begin
						xfer_addr[15:8] = c;
						open_code = TX_NONE;
					end
					CMD_LENGTH: begin
						xfer_len = c;
						open_code = TX_NONE;
					end
					CMD_WRITE: begin
						if (c == CONFIRM_WR) open_code = TX_DATA;
						else ok = 1'b0;
					end
					TX_DATA: begin
						if (store_index(idx)) begin
							scratch_mem[idx] = c;
							store_writes++;
						end
						xfer_addr++;
						xfer_len--;
						if (xfer_len == '0) open_code = TX_NONE;
					end
					CMD_READ: begin
						if (c == CONFIRM_RD) begin
							r.reply_zero = stream_byte();
							r.reply_one = stream_byte();
							r.reply_two = stream_byte();
							r.reply_three = stream_byte();
							streamed = 1'b1;
						end else begin
							ok = 1'b0;
						end
					end
					default: ok = 1'b0;
				endcase
				if (!streamed) begin
					r.reply_zero = c;
					r.reply_one = c;
					r.reply_two = c;
					r.reply_three = ok ? c : BYTE_ERR;
					if (!ok) open_code = TX_NONE;
				end
			end else begin
				case (c)
					CMD_VERSION: begin
						r.reply_zero = regs.ver_major;
						r.reply_one = regs.ver_minor;
						r.reply_two = regs.ver_patch;
					end
					CMD_DIGITAL: begin
						r.reply_zero = d.raw_digital[15:8];
						r.reply_one = d.raw_digital[7:0];
					end
					CMD_ANALOG_A: begin
						r.reply_zero = d.analog_one;
						r.reply_one = d.analog_two;
						r.reply_two = d.analog_three;
					end
					CMD_ANALOG_B: begin
						r.reply_zero = d.analog_four;
						r.reply_one = d.analog_five;
						r.reply_two = d.analog_six;
					end
					CMD_COMMIT: begin
						r.settings_request = REQ_COMMIT;
						r.reply_zero = regs.map_size;
					end
					CMD_PLAYER: begin
						player_sel = scratch_mem[0][0];
						r.reply_zero = {7'b0, player_sel};
					end
					CMD_SAVE: begin
						r.settings_request = REQ_SAVE;
						r.reply_zero = regs.map_size;
					end
					CMD_LOAD: begin
						r.settings_request = REQ_LOAD;
						r.reply_zero = regs.map_size;
					end
					CMD_MODE: begin
						r.mode_write = 1'b1;
						r.mode_value = scratch_mem[0];
						r.reply_zero = scratch_mem[0];
					end
					CMD_SPACE, CMD_ADDR_LO, CMD_ADDR_HI, CMD_LENGTH, CMD_WRITE, CMD_READ: begin
						open_code = c;
						stream_check = '0;
						r.reply_zero = c;
						r.reply_one = c;
						r.reply_two = c;
					end
					default: begin
						ok = 1'b0;
						r.reply_zero = c;
						r.reply_one = BYTE_FILL;
						r.reply_two = BYTE_FILL;
						r.reply_three = BYTE_ERR;
					end
				endcase
				if (ok) r.reply_three = c ^ r.reply_zero ^ r.reply_one ^ r.reply_two;
			end
			if (!ok) error_replies++;
			r.player_select = player_sel;
			return r;
		endfunction

		function void take_request(in_t d);
			awaited_replies.push_back(next_reply(d));
			requests_taken++;
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void match_reply(out_t got);
			out_t want;
			if (awaited_replies.size() == 0) begin
				$error("reply %h with no request outstanding", got);
				mismatches++;
				return;
			end
			want = awaited_replies.pop_front();
			check_field("reply_zero", want.reply_zero, got.reply_zero);
			check_field("reply_one", want.reply_one, got.reply_one);
			check_field("reply_two", want.reply_two, got.reply_two);
			check_field("reply_three", want.reply_three, got.reply_three);
			check_field("player_select", 8'(want.player_select), 8'(got.player_select));
			check_field("settings_request", 8'(want.settings_request), 8'(got.settings_request));
			check_field("mode_write", 8'(want.mode_write), 8'(got.mode_write));
			check_field("mode_value", want.mode_value, got.mode_value);
			replies_matched++;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	host_engine_mirror engine;
	int requests_sent;
	int quiet_cycles;
	int settings_used;
	bit steady_in;
	bit steady_out;
	logic [7:0] plain_cmds [9] = '{CMD_VERSION, CMD_DIGITAL, CMD_ANALOG_A, CMD_ANALOG_B,
		CMD_COMMIT, CMD_PLAYER, CMD_SAVE, CMD_LOAD, CMD_MODE};

	host_command_transfer_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sample every handshake at the edge, before any driver update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) engine.write_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) engine.take_request(in_data);
			if (out_valid && !out_stall) engine.match_reply(out_data);
			if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= IDLE_LIMIT);
		$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : reply_sink
		int stall_cycles;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall_cycles = steady_out ? 0 : $urandom_range(0, 10);
			if ($urandom_range(0, 29) == 0) steady_out = !steady_out;
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic in_t make_request(logic [7:0] cmd);
		in_t d;
		d.command_byte = cmd;
		d.raw_digital = 16'($urandom);
		d.analog_one = 8'($urandom);
		d.analog_two = 8'($urandom);
		d.analog_three = 8'($urandom);
		d.analog_four = 8'($urandom);
		d.analog_five = 8'($urandom);
		d.analog_six = 8'($urandom);
		return d;
	endfunction

	// valid only drops when a gap follows, so it never toggles within one step
	task automatic send_request(in_t d);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, 10);
		if ($urandom_range(0, 24) == 0) steady_in = !steady_in;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic send_byte(logic [7:0] cmd);
		send_request(make_request(cmd));
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (engine.awaited_replies.size() != 0) @(posedge clk);
	endtask

	task automatic program_registers(cfg_t v);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [7:0] val [5];
		idx = '{REG_VER_MAJOR, REG_VER_MINOR, REG_VER_PATCH, REG_MAP_SIZE,
			REG_MAP_SIZE + CFG_IDX_W'($urandom_range(1, 252))};
		val = '{v.ver_major, v.ver_minor, v.ver_patch, v.map_size, 8'($urandom)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// a zero length keeps the write open for a full 256 data bytes
	task automatic write_block(int count);
		send_byte(CMD_LENGTH);
		send_byte(8'(count));
		send_byte(CMD_WRITE);
		send_byte(CONFIRM_WR);
		repeat (count == 0 ? 256 : count) send_byte(8'($urandom));
	endtask

	task automatic read_block(int count);
		send_byte(CMD_LENGTH);
		send_byte(8'(count));
		send_byte(CMD_READ);
		send_byte(CONFIRM_RD);
		for (int i = 0; i < count / 4; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_byte(8'($urandom));
				break;
			end
			send_byte(CONFIRM_RD);
		end
	endtask

	task automatic directed_requests();
		in_t d;
		send_byte(CMD_VERSION);
		d = make_request(CMD_DIGITAL);
		d.raw_digital = '1;
		send_request(d);
		d = make_request(CMD_DIGITAL);
		d.raw_digital = '0;
		send_request(d);
		d = make_request(CMD_ANALOG_A);
		{d.analog_one, d.analog_two, d.analog_three} = '1;
		send_request(d);
		d = make_request(CMD_ANALOG_B);
		{d.analog_four, d.analog_five, d.analog_six} = '0;
		send_request(d);
		send_byte(CMD_COMMIT);
		send_byte(CMD_SAVE);
		send_byte(CMD_LOAD);
		send_byte(8'h05);
		send_byte(8'hff);
		// bad confirm on both directions
		send_byte(CMD_WRITE);
		send_byte(8'h00);
		send_byte(CMD_READ);
		send_byte(CONFIRM_WR);
		// two bytes into the store from address zero, then use byte zero
		send_byte(CMD_LENGTH);
		send_byte(8'd2);
		send_byte(CMD_WRITE);
		send_byte(CONFIRM_WR);
		send_byte(8'h81);
		send_byte(8'h7e);
		send_byte(CMD_PLAYER);
		send_byte(CMD_MODE);
		// length now spent, so the stream closes at once with its check
		send_byte(CMD_READ);
		send_byte(CONFIRM_RD);
	endtask

	task automatic random_requests(int goal);
		int pick;
		while (requests_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_byte(plain_cmds[$urandom_range(0, 8)]);
			end else if (pick < 38) begin
				send_byte(8'($urandom));
			end else if (pick < 46) begin
				send_byte(CMD_SPACE);
				send_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
			end else if (pick < 56) begin
				send_byte(CMD_ADDR_LO);
				send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom));
			end else if (pick < 60) begin
				send_byte(CMD_ADDR_HI);
				send_byte(8'($urandom));
			end else if (pick < 64) begin
				send_byte(CMD_LENGTH);
				send_byte(8'($urandom));
			end else if (pick < 80) begin
				write_block($urandom_range(1, 6));
			end else if (pick < 96) begin
				read_block($urandom_range(0, 12));
			end else begin
				send_byte($urandom_range(0, 1) ? CMD_WRITE : CMD_READ);
				send_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		cfg_t setting;
		engine = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) setting = '0;
			else if (phase == 1) setting = '1;
			else setting = cfg_t'($urandom);
			program_registers(setting);
			if (phase == 0) directed_requests();
			if (phase == 1) write_block(0);
			random_requests((phase + 1) * REQUESTS_PER_PHASE);
			in_valid <= 1'b0;
			wait_idle();
		end
		repeat (20) @(posedge clk);
		if (engine.awaited_replies.size() != 0) begin
			$error("%0d replies never arrived", engine.awaited_replies.size());
			engine.mismatches++;
		end
		$display("covered %0d requests and %0d replies under %0d register settings",
			engine.requests_taken, engine.replies_matched, settings_used);
		$display("store writes %0d, streamed bytes %0d, error replies %0d",
			engine.store_writes, engine.streamed_bytes, engine.error_replies);
		if (engine.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
